// ===== hw/rtl/pcapng_pkg.sv =====
// Package for the pcapng block stream parser: phase codes, block types,
// result kinds, error codes and byte-order helpers. No dependencies.
package pcapng_pkg;

    localparam logic [3:0] PH_HDR            = 4'd0;
    localparam logic [3:0] PH_MAGIC          = 4'd1;
    localparam logic [3:0] PH_SHB_BODY       = 4'd2;
    localparam logic [3:0] PH_SHB_TRAILER    = 4'd3;
    localparam logic [3:0] PH_BODY           = 4'd4;
    localparam logic [3:0] PH_STREAM         = 4'd5;
    localparam logic [3:0] PH_TRAILER        = 4'd6;
    localparam logic [3:0] PH_STREAM_TRAILER = 4'd7;

    localparam logic [31:0] SHB_MARK = 32'h0A0D0D0A;
    localparam logic [31:0] MAGIC_LE = 32'h4D3C2B1A;
    localparam logic [31:0] MAGIC_BE = 32'h1A2B3C4D;
    localparam logic [31:0] TYPE_IDB = 32'd1;
    localparam logic [31:0] TYPE_SPB = 32'd3;
    localparam logic [31:0] TYPE_EPB = 32'd6;

    localparam logic [2:0] RK_HEADER  = 3'd0;
    localparam logic [2:0] RK_PAYLOAD = 3'd1;
    localparam logic [2:0] RK_DONE    = 3'd2;
    localparam logic [2:0] RK_END     = 3'd3;
    localparam logic [2:0] RK_ERROR   = 3'd4;

    localparam logic [3:0] ERR_TRUNC_HDR   = 4'd0;
    localparam logic [3:0] ERR_SHORT_READ  = 4'd1;
    localparam logic [3:0] ERR_BAD_MAGIC   = 4'd2;
    localparam logic [3:0] ERR_SHB_LEN     = 4'd3;
    localparam logic [3:0] ERR_SHB_TRAILER = 4'd4;
    localparam logic [3:0] ERR_NO_SHB      = 4'd5;
    localparam logic [3:0] ERR_BAD_LEN     = 4'd6;
    localparam logic [3:0] ERR_TRAILER     = 4'd7;
    localparam logic [3:0] ERR_IDB_SHORT   = 4'd8;
    localparam logic [3:0] ERR_EPB_SHORT   = 4'd9;
    localparam logic [3:0] ERR_EPB_TRUNC   = 4'd10;
    localparam logic [3:0] ERR_SPB_SHORT   = 4'd11;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] interface_id;
        logic [63:0] timestamp;
        logic [15:0] link_type;
        logic [31:0] captured_length;
        logic [7:0]  payload_byte;
        logic [3:0]  error_code;
    } result_t;

    function automatic logic [31:0] order32(input logic le, input logic [31:0] raw);
        return le ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
    endfunction

endpackage

// ===== hw/rtl/pcapng_core.sv =====
// Per-byte parse step: block state registers and the link type table.
// Depends on pcapng_pkg.
module pcapng_core
    import pcapng_pkg::*;
#(
    parameter int MAX_INTERFACES = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_end,
    input  logic [7:0] in_byte,
    output logic    res_valid,
    output result_t res
);

    localparam int IW = (MAX_INTERFACES > 1) ? $clog2(MAX_INTERFACES) : 1;
    localparam int CW = $clog2(MAX_INTERFACES + 1);

    logic [3:0]  phase_reg, phase_next;
    logic        le_reg, le_next, seen_reg, seen_next, halt_reg, halt_next;
    logic [31:0] cnt_reg, cnt_next, kind_reg, kind_next, tlen_reg, tlen_next;
    logic [31:0] asm_reg, asm_next;
    logic [3:0]  hb_reg, hb_next;
    logic [CW-1:0] icnt_reg, icnt_next;
    logic [15:0] plt_reg, plt_next;
    logic [31:0] pif_reg, pif_next, pcap_reg, pcap_next;
    logic [63:0] pts_reg, pts_next;
    logic [15:0] lt_table [MAX_INTERFACES];
    logic        wr_en;
    logic [15:0] wr_data;

    logic [31:0] asm_sh, w, body, idx, start, hk, ht;
    logic [15:0] lt;
    logic        emit;
    result_t     r;

    always_comb
    begin
        phase_next = phase_reg; le_next = le_reg; seen_next = seen_reg;
        halt_next = halt_reg; cnt_next = cnt_reg; kind_next = kind_reg;
        tlen_next = tlen_reg; asm_next = asm_reg; hb_next = hb_reg;
        icnt_next = icnt_reg; plt_next = plt_reg; pif_next = pif_reg;
        pts_next = pts_reg; pcap_next = pcap_reg;
        wr_en = 1'b0; wr_data = 16'd0;
        emit = 1'b0; r = '0;
        asm_sh = {asm_reg[23:0], in_byte};
        w = order32(le_reg, asm_sh);
        body = tlen_reg - 32'd12;
        idx = cnt_reg;
        start = (kind_reg == TYPE_EPB) ? 32'd20 : 32'd4;
        hk = 32'd0; ht = 32'd0;
        lt = 16'd0;
        if (kind_reg == TYPE_EPB)
        begin
            if (pif_next < 32'(icnt_reg))
                lt = lt_table[pif_next[IW-1:0]];
        end
        else if (icnt_reg != '0)
        begin
            lt = lt_table[0];
        end
        if (in_valid && !halt_reg)
        begin
            if (in_end)
            begin
                emit = 1'b1;
                if (phase_reg == PH_HDR && hb_reg == 4'd0)
                    r.result_kind = RK_END;
                else
                begin
                    r.result_kind = RK_ERROR;
                    r.error_code = (phase_reg == PH_HDR) ? ERR_TRUNC_HDR : ERR_SHORT_READ;
                    halt_next = 1'b1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_HDR:
                    begin
                        if (hb_reg < 4'd4)
                            kind_next = {kind_reg[23:0], in_byte};
                        else
                            tlen_next = {tlen_reg[23:0], in_byte};
                        hb_next = hb_reg + 4'd1;
                        if (hb_reg == 4'd7)
                        begin
                            hb_next = 4'd0;
                            asm_next = 32'd0;
                            hk = order32(le_reg, kind_reg);
                            ht = order32(le_reg, tlen_next);
                            if (kind_reg == SHB_MARK)
                                phase_next = PH_MAGIC;
                            else if (!seen_reg)
                            begin
                                emit = 1'b1; halt_next = 1'b1;
                                r.result_kind = RK_ERROR; r.error_code = ERR_NO_SHB;
                            end
                            else
                            begin
                                kind_next = hk;
                                tlen_next = ht;
                                if (ht < 32'd12 || ht[1:0] != 2'd0)
                                begin
                                    emit = 1'b1; halt_next = 1'b1;
                                    r.result_kind = RK_ERROR; r.error_code = ERR_BAD_LEN;
                                end
                                else
                                begin
                                    cnt_next = 32'd0;
                                    plt_next = 16'd0;
                                    phase_next = (ht == 32'd12) ? PH_TRAILER : PH_BODY;
                                end
                            end
                        end
                    end
                    PH_MAGIC:
                    begin
                        asm_next = asm_sh;
                        hb_next = hb_reg + 4'd1;
                        if (hb_reg == 4'd3)
                        begin
                            if (asm_sh != MAGIC_LE && asm_sh != MAGIC_BE)
                            begin
                                emit = 1'b1; halt_next = 1'b1;
                                r.result_kind = RK_ERROR; r.error_code = ERR_BAD_MAGIC;
                            end
                            else
                            begin
                                le_next = (asm_sh == MAGIC_LE);
                                seen_next = 1'b1;
                                ht = order32(le_next, tlen_reg);
                                tlen_next = ht;
                                if (ht < 32'd16 || ht[1:0] != 2'd0)
                                begin
                                    emit = 1'b1; halt_next = 1'b1;
                                    r.result_kind = RK_ERROR; r.error_code = ERR_SHB_LEN;
                                end
                                else
                                begin
                                    cnt_next = 32'd0; hb_next = 4'd0; asm_next = 32'd0;
                                    phase_next = (ht == 32'd16) ? PH_SHB_TRAILER
                                                                 : PH_SHB_BODY;
                                end
                            end
                        end
                    end
                    PH_SHB_BODY:
                    begin
                        cnt_next = cnt_reg + 32'd1;
                        if (cnt_next == tlen_reg - 32'd16)
                            phase_next = PH_SHB_TRAILER;
                    end
                    PH_SHB_TRAILER:
                    begin
                        asm_next = asm_sh;
                        hb_next = hb_reg + 4'd1;
                        if (hb_reg == 4'd3)
                        begin
                            hb_next = 4'd0;
                            phase_next = PH_HDR;
                            if (w != tlen_reg)
                            begin
                                emit = 1'b1; halt_next = 1'b1;
                                r.result_kind = RK_ERROR; r.error_code = ERR_SHB_TRAILER;
                            end
                        end
                    end
                    PH_BODY, PH_STREAM:
                    begin
                        asm_next = asm_sh;
                        if (phase_reg == PH_BODY)
                        begin
                            if (kind_reg == TYPE_IDB && idx < 32'd2)
                                plt_next = {plt_reg[7:0], in_byte};
                            else if (kind_reg == TYPE_EPB)
                            begin
                                if (idx == 32'd3)
                                    pif_next = w;
                                else if (idx == 32'd7)
                                    pts_next = {w, 32'd0};
                                else if (idx == 32'd11)
                                    pts_next = {pts_reg[63:32], w};
                                else if (idx == 32'd15)
                                begin
                                    pcap_next = w;
                                    if (body >= 32'd20 && w <= body - 32'd20)
                                    begin
                                        emit = 1'b1;
                                        phase_next = PH_STREAM;
                                    end
                                end
                            end
                            else if (kind_reg == TYPE_SPB && idx == 32'd3)
                            begin
                                pif_next = 32'd0;
                                pts_next = 64'd0;
                                pcap_next = body - 32'd4;
                                emit = 1'b1;
                                phase_next = PH_STREAM;
                            end
                            if (emit)
                            begin
                                r.result_kind = RK_HEADER;
                                r.interface_id = pif_next;
                                r.timestamp = pts_reg;
                                if (kind_reg == TYPE_SPB)
                                    r.timestamp = 64'd0;
                                r.link_type = lt;
                                r.captured_length = pcap_next;
                            end
                        end
                        else if (idx >= start && idx - start < pcap_reg)
                        begin
                            emit = 1'b1;
                            r.result_kind = RK_PAYLOAD;
                            r.payload_byte = in_byte;
                        end
                        cnt_next = idx + 32'd1;
                        if (cnt_next == body)
                        begin
                            phase_next = (phase_next == PH_STREAM) ? PH_STREAM_TRAILER
                                                                   : PH_TRAILER;
                            hb_next = 4'd0;
                            asm_next = 32'd0;
                        end
                    end
                    PH_TRAILER, PH_STREAM_TRAILER:
                    begin
                        asm_next = asm_sh;
                        hb_next = hb_reg + 4'd1;
                        if (hb_reg == 4'd3)
                        begin
                            phase_next = PH_HDR;
                            hb_next = 4'd0;
                            if (w != tlen_reg)
                            begin
                                emit = 1'b1; halt_next = 1'b1;
                                r.result_kind = RK_ERROR; r.error_code = ERR_TRAILER;
                            end
                            else if (phase_reg == PH_STREAM_TRAILER)
                            begin
                                emit = 1'b1;
                                r.result_kind = RK_DONE;
                            end
                            else if (kind_reg == TYPE_IDB)
                            begin
                                if (body < 32'd8)
                                begin
                                    emit = 1'b1; halt_next = 1'b1;
                                    r.result_kind = RK_ERROR; r.error_code = ERR_IDB_SHORT;
                                end
                                else if (32'(icnt_reg) < MAX_INTERFACES)
                                begin
                                    wr_en = 1'b1;
                                    wr_data = le_reg ? {plt_reg[7:0], plt_reg[15:8]} : plt_reg;
                                    icnt_next = icnt_reg + CW'(1);
                                end
                            end
                            else if (kind_reg == TYPE_EPB)
                            begin
                                emit = 1'b1; halt_next = 1'b1;
                                r.result_kind = RK_ERROR;
                                r.error_code = (body < 32'd20) ? ERR_EPB_SHORT : ERR_EPB_TRUNC;
                            end
                            else if (kind_reg == TYPE_SPB)
                            begin
                                emit = 1'b1; halt_next = 1'b1;
                                r.result_kind = RK_ERROR; r.error_code = ERR_SPB_SHORT;
                            end
                        end
                    end
                    default:
                    begin
                        emit = 1'b1; halt_next = 1'b1;
                        r.result_kind = RK_ERROR; r.error_code = ERR_SHORT_READ;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            lt_table[icnt_reg[IW-1:0]] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR; le_reg <= 1'b0; seen_reg <= 1'b0; halt_reg <= 1'b0;
            cnt_reg <= '0; kind_reg <= '0; tlen_reg <= '0; asm_reg <= '0;
            hb_reg <= '0; icnt_reg <= '0; plt_reg <= '0; pif_reg <= '0;
            pts_reg <= '0; pcap_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next; le_reg <= le_next; seen_reg <= seen_next;
            halt_reg <= halt_next; cnt_reg <= cnt_next; kind_reg <= kind_next;
            tlen_reg <= tlen_next; asm_reg <= asm_next; hb_reg <= hb_next;
            icnt_reg <= icnt_next; plt_reg <= plt_next; pif_reg <= pif_next;
            pts_reg <= pts_next; pcap_reg <= pcap_next;
        end
    end

    assign res_valid = emit;
    assign res = r;

endmodule

// ===== hw/rtl/pcapng_out.sv =====
// Two-entry output skid buffer for result beats.
// Depends on pcapng_pkg.
module pcapng_out
    import pcapng_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    out_valid,
    output result_t out_data,
    input  logic    out_ready
);

    logic [1:0] cnt_reg, cnt_next;
    result_t    e0_reg, e1_reg;
    logic       pop;

    assign pop = out_valid && out_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data = e0_reg;
    // A beat accepted now pushes its result in the next cycle, so at most one entry may be
    // held after this edge.
    assign space = (cnt_next != 2'd2);

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (cnt_reg == 2'd2)
                e0_reg <= e1_reg;
            else if (push)
                e0_reg <= push_data;
            if (cnt_reg == 2'd2 && push)
                e1_reg <= push_data;
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
                e0_reg <= push_data;
            else
                e1_reg <= push_data;
        end
    end

endmodule

// ===== hw/rtl/pcapng_block_stream_parser.sv =====
// Streaming pcapng parser top level: input register, parse core, result buffer.
// Depends on pcapng_pkg, pcapng_core and pcapng_out.
// One capture byte per beat on s_axis is taken each cycle while s_axis_tready is high
// and produces at most one result in the next cycle; a two-entry result buffer keeps
// full rate while m_axis accepts. Any error halts the parser until reset.
module pcapng_block_stream_parser
    import pcapng_pkg::*;
#(
    parameter int MAX_INTERFACES = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic         s_axis_tuser,   // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,   // interface_id, timestamp, link_type,
                                         // captured_length, payload_byte, error_code, pad
    output logic [2:0]   m_axis_tuser    // result_kind
);

    logic       iv_reg, ie_reg;
    logic [7:0] ib_reg;
    logic       rv;
    result_t    r, o;
    logic       space;

    // Ready only when the buffer can absorb the registered item's result.
    assign s_axis_tready = space && !(iv_reg && !space);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iv_reg <= 1'b0;
        else
            iv_reg <= s_axis_tvalid && s_axis_tready;
    end

    always_ff @(posedge clk)
    begin
        ie_reg <= s_axis_tuser;
        ib_reg <= s_axis_tdata;
    end

    pcapng_core #(.MAX_INTERFACES(MAX_INTERFACES)) u_core (
        .clk(clk), .rst_n(rst_n), .in_valid(iv_reg), .in_end(ie_reg),
        .in_byte(ib_reg), .res_valid(rv), .res(r)
    );

    pcapng_out u_out (
        .clk(clk), .rst_n(rst_n), .push(rv), .push_data(r), .space(space),
        .out_valid(m_axis_tvalid), .out_data(o), .out_ready(m_axis_tready)
    );

    assign m_axis_tuser = o.result_kind;
    assign m_axis_tdata = {4'd0, o.error_code, o.payload_byte, o.captured_length,
                           o.link_type, o.timestamp, o.interface_id};

endmodule

// ===== hw/rtl/pcapng_checker.sv =====
// Port-level checker for the pcapng parser, bound to the top level.
// Depends on pcapng_pkg.
module pcapng_checker
    import pcapng_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [159:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser
);

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser <= RK_ERROR)
        else $error("bad result kind");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == RK_ERROR |-> m_axis_tdata[155:152] <= ERR_SPB_SHORT)
        else $error("bad error code");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[159:156] == 4'd0)
        else $error("pad bits set");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid)
        else $error("input beat withdrawn while stalled");

endmodule

bind pcapng_block_stream_parser pcapng_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);
